>>> rtl/core/rflp_pkg.sv
package rflp_pkg;

  // Default sizes of the task tables
  localparam int MaxResources = 8;
  localparam int MaxTasks     = 16;

  // Fixed field widths
  localparam int TimeW   = 27;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_RESOURCE_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CHOICE_MODE    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HORIZON        = 2'd2;

  // Input opcodes
  localparam logic [1:0] OP_SET_TASK   = 2'd0;
  localparam logic [1:0] OP_SET_COUNT  = 2'd1;
  localparam logic [1:0] OP_DISTRIBUTE = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_FIRSTS   = 2'd0;
  localparam logic [1:0] KIND_LASTS    = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;
  localparam logic [1:0] KIND_FAILED   = 2'd3;

  // List selectors
  localparam logic [1:0] LIST_CAND  = 2'd0;
  localparam logic [1:0] LIST_UNORD = 2'd1;
  localparam logic [1:0] LIST_NONE  = 2'd2;

  // Choice modes
  localparam logic [1:0] MODE_COUNT  = 2'd0;
  localparam logic [1:0] MODE_FIRSTS = 2'd1;
  localparam logic [1:0] MODE_LASTS  = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [2:0]       resource;
    logic [3:0]       task_req;
    logic [TimeW-1:0] earliest;
    logic [TimeW-1:0] latest;
    logic [TimeW-1:0] duration;
    logic [4:0]       count;
    logic             has_task;
  } rflp_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] list_sel;
    logic [3:0] task_id;
    logic [2:0] resource_id;
    logic       last;
  } rflp_out_t;

  // Datapath commands
  typedef enum logic [5:0] {
    CMD_NOP,
    CMD_CAPTURE,
    CMD_WR_TASK,
    CMD_WR_COUNT,
    CMD_MARK,
    CMD_CHECK,
    CMD_SEL_SINGLE,
    CMD_SEL_INIT,
    CMD_SEL_SKIP,
    CMD_SCAN_INIT,
    CMD_READ_J,
    CMD_J_LOAD,
    CMD_J_INC,
    CMD_READ_K,
    CMD_K_LOAD,
    CMD_K_INC,
    CMD_READ_L,
    CMD_L_ACC,
    CMD_VAL_CALC,
    CMD_VAL_MIN,
    CMD_GS_CALC,
    CMD_SEL_CMP,
    CMD_BR_INIT,
    CMD_P1_ACC,
    CMD_P2_INIT,
    CMD_P2_ACC,
    CMD_DIFF,
    CMD_CHOOSE,
    CMD_EMIT_CAND,
    CMD_E_INC,
    CMD_EM_DOWN_INIT,
    CMD_E_DEC,
    CMD_EMIT_UO,
    CMD_EMIT_NONE,
    CMD_EMIT_FAIL,
    CMD_EMIT_FIN
  } dp_cmd_e;

  // Datapath status towards the controller
  typedef struct packed {
    logic [1:0] op;
    logic       cur_valid;
    logic       all_ordered;
    logic       single;
    logic       i_end;
    logic       i_done;
    logic       j_end;
    logic       k_end;
    logic       l_end;
    logic       cond_jk;
    logic       j_ordered;
    logic       fail;
    logic       e_full;
    logic       cand_bit;
    logic       e_zero;
    logic       uo_bit;
    logic       uo_is_lo;
    logic       none;
    logic       out_free;
  } rflp_status_t;

endpackage

>>> rtl/core/rflp_ctrl.sv
module rflp_ctrl import rflp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  rflp_status_t st_i,
  output dp_cmd_e      cmd_o
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DECODE    = 5'd1;
  localparam logic [4:0] S_CHECK     = 5'd2;
  localparam logic [4:0] S_SEL_START = 5'd3;
  localparam logic [4:0] S_SEL_NEXT  = 5'd4;
  localparam logic [4:0] S_J_TEST    = 5'd5;
  localparam logic [4:0] S_J_GOT     = 5'd6;
  localparam logic [4:0] S_K_TEST    = 5'd7;
  localparam logic [4:0] S_K_GOT     = 5'd8;
  localparam logic [4:0] S_L_TEST    = 5'd9;
  localparam logic [4:0] S_L_GOT     = 5'd10;
  localparam logic [4:0] S_VAL_CMP   = 5'd11;
  localparam logic [4:0] S_SEL_CMP   = 5'd12;
  localparam logic [4:0] S_FIN       = 5'd13;
  localparam logic [4:0] S_BR_START  = 5'd14;
  localparam logic [4:0] S_P1_TEST   = 5'd15;
  localparam logic [4:0] S_P1_GOT    = 5'd16;
  localparam logic [4:0] S_P2_TEST   = 5'd17;
  localparam logic [4:0] S_P2_GOT    = 5'd18;
  localparam logic [4:0] S_DECIDE    = 5'd19;
  localparam logic [4:0] S_CHOOSE    = 5'd20;
  localparam logic [4:0] S_FAIL      = 5'd21;
  localparam logic [4:0] S_EM_CAND   = 5'd22;
  localparam logic [4:0] S_EM_UO     = 5'd23;
  localparam logic [4:0] S_EM_NONE   = 5'd24;

  logic [4:0] state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencing
  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_CAPTURE;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st_i.op)
          OP_SET_TASK: begin
            cmd_o   = CMD_WR_TASK;
            state_d = S_IDLE;
          end
          OP_SET_COUNT: begin
            cmd_o   = CMD_WR_COUNT;
            state_d = S_IDLE;
          end
          OP_DISTRIBUTE: begin
            if (st_i.cur_valid) begin
              cmd_o   = CMD_MARK;
              state_d = S_CHECK;
            end else begin
              state_d = S_SEL_START;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_CHECK: begin
        cmd_o   = CMD_CHECK;
        state_d = st_i.all_ordered ? S_SEL_START : S_BR_START;
      end
      S_SEL_START: begin
        if (st_i.single) begin
          cmd_o   = CMD_SEL_SINGLE;
          state_d = S_BR_START;
        end else begin
          cmd_o   = CMD_SEL_INIT;
          state_d = S_SEL_NEXT;
        end
      end
      S_SEL_NEXT: begin
        if (st_i.i_end) begin
          state_d = st_i.cur_valid ? S_BR_START : S_FIN;
        end else if (st_i.i_done) begin
          cmd_o = CMD_SEL_SKIP;
        end else begin
          cmd_o   = CMD_SCAN_INIT;
          state_d = S_J_TEST;
        end
      end
      // slack scan: outer task j
      S_J_TEST: begin
        if (st_i.j_end) begin
          cmd_o   = CMD_GS_CALC;
          state_d = S_SEL_CMP;
        end else begin
          cmd_o   = CMD_READ_J;
          state_d = S_J_GOT;
        end
      end
      S_J_GOT: begin
        cmd_o   = CMD_J_LOAD;
        state_d = S_K_TEST;
      end
      // interval end task k
      S_K_TEST: begin
        if (st_i.k_end) begin
          cmd_o   = CMD_J_INC;
          state_d = S_J_TEST;
        end else begin
          cmd_o   = CMD_READ_K;
          state_d = S_K_GOT;
        end
      end
      S_K_GOT: begin
        if (st_i.cond_jk) begin
          cmd_o   = CMD_K_LOAD;
          state_d = S_L_TEST;
        end else begin
          cmd_o   = CMD_K_INC;
          state_d = S_K_TEST;
        end
      end
      // demand over tasks l inside the interval
      S_L_TEST: begin
        if (st_i.l_end) begin
          cmd_o   = CMD_VAL_CALC;
          state_d = S_VAL_CMP;
        end else begin
          cmd_o   = CMD_READ_L;
          state_d = S_L_GOT;
        end
      end
      S_L_GOT: begin
        cmd_o   = CMD_L_ACC;
        state_d = S_L_TEST;
      end
      S_VAL_CMP: begin
        cmd_o   = CMD_VAL_MIN;
        state_d = S_K_TEST;
      end
      S_SEL_CMP: begin
        cmd_o   = CMD_SEL_CMP;
        state_d = S_SEL_NEXT;
      end
      S_FIN: begin
        if (st_i.out_free) begin
          cmd_o   = CMD_EMIT_FIN;
          state_d = S_IDLE;
        end
      end
      // branching on the current resource
      S_BR_START: begin
        cmd_o   = CMD_BR_INIT;
        state_d = S_P1_TEST;
      end
      S_P1_TEST: begin
        if (st_i.j_end) begin
          cmd_o   = CMD_P2_INIT;
          state_d = S_P2_TEST;
        end else if (st_i.j_ordered) begin
          cmd_o = CMD_J_INC;
        end else begin
          cmd_o   = CMD_READ_J;
          state_d = S_P1_GOT;
        end
      end
      S_P1_GOT: begin
        cmd_o   = CMD_P1_ACC;
        state_d = S_P1_TEST;
      end
      S_P2_TEST: begin
        if (st_i.j_end) begin
          state_d = S_DECIDE;
        end else if (st_i.j_ordered) begin
          cmd_o = CMD_J_INC;
        end else begin
          cmd_o   = CMD_READ_J;
          state_d = S_P2_GOT;
        end
      end
      S_P2_GOT: begin
        cmd_o   = CMD_P2_ACC;
        state_d = S_P2_TEST;
      end
      S_DECIDE: begin
        if (st_i.fail) begin
          state_d = S_FAIL;
        end else begin
          cmd_o   = CMD_DIFF;
          state_d = S_CHOOSE;
        end
      end
      S_CHOOSE: begin
        cmd_o   = CMD_CHOOSE;
        state_d = S_EM_CAND;
      end
      S_FAIL: begin
        if (st_i.out_free) begin
          cmd_o   = CMD_EMIT_FAIL;
          state_d = S_IDLE;
        end
      end
      // candidates ascending
      S_EM_CAND: begin
        if (st_i.e_full) begin
          cmd_o   = CMD_EM_DOWN_INIT;
          state_d = st_i.none ? S_EM_NONE : S_EM_UO;
        end else if (!st_i.cand_bit) begin
          cmd_o = CMD_E_INC;
        end else if (st_i.out_free) begin
          cmd_o = CMD_EMIT_CAND;
        end
      end
      // unordered tasks descending
      S_EM_UO: begin
        if (st_i.e_zero) begin
          state_d = S_IDLE;
        end else if (!st_i.uo_bit) begin
          cmd_o = CMD_E_DEC;
        end else if (st_i.out_free) begin
          cmd_o = CMD_EMIT_UO;
          if (st_i.uo_is_lo) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EM_NONE: begin
        if (st_i.out_free) begin
          cmd_o   = CMD_EMIT_NONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/rflp_dp.sv
module rflp_dp import rflp_pkg::*; #(
  parameter int MAX_RESOURCES = MaxResources,
  parameter int MAX_TASKS     = MaxTasks
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_e            cmd_i,
  output rflp_status_t       st_o,
  input  rflp_in_t           in_item_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rflp_out_t          out_item_o
);

  localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int RCW   = $clog2(MAX_RESOURCES + 1);
  localparam int TW    = $clog2(MAX_TASKS);
  localparam int CW    = $clog2(MAX_TASKS + 1);
  localparam int Depth = MAX_RESOURCES * MAX_TASKS;
  localparam int SlotW = $clog2(Depth);
  localparam int DueW  = TimeW + 1;
  localparam int SlkW  = TimeW + CW + 2;

  // task tables
  logic [TimeW-1:0] mem_e [Depth];
  logic [TimeW-1:0] mem_l [Depth];
  logic [TimeW-1:0] mem_d [Depth];
  logic [TimeW-1:0] rd_e_q, rd_l_q, rd_d_q;

  rflp_in_t         item_q;
  logic [3:0]       rc_q;
  logic [1:0]       mode_q;
  logic [TimeW-1:0] hz_q;

  logic [CW-1:0]        cnt_q [MAX_RESOURCES];
  logic [MAX_TASKS-1:0] ord_q [MAX_RESOURCES];
  logic [MAX_RESOURCES-1:0] done_q;
  logic [RW-1:0]        cur_q, rsel_q;
  logic                 cur_valid_q;

  logic [RCW-1:0] i_q;
  logic [CW-1:0]  j_q, k_q, l_q, e_q, hm_q, nf_q, nl_q;

  logic signed [SlkW-1:0] jm_q, jd_q, kd_q, dem_q, val_q, cs_q;
  logic signed [SlkW-1:0] gmin_q, gmax_q, gdur_q, gs_q, best_q, bestg_q;
  logic signed [SlkW-1:0] sum_q, max1_q, max2_q, min1_q, min2_q;
  logic signed [SlkW-1:0] a_val_q, b_val_q, c_val_q, e_val_q, d1_q, d2_q;
  logic                   a_has_q, b_has_q, c_has_q, e_has_q;

  logic [TW-1:0]        only_q, lo_q;
  logic [MAX_TASKS-1:0] fmask_q, lmask_q, uo_q, cand_q;
  logic [1:0]           kind_q;

  logic      out_valid_q;
  rflp_out_t out_q, out_d;
  logic      out_load;

  // derived values
  logic [DueW-1:0]        due_u;
  logic signed [SlkW-1:0] ext_e, ext_due, ext_dur, hz_s;
  logic signed [SlkW-1:0] up, down;
  logic [CW-1:0]          ct_sel, ct_cur, rd_idx, e_m1;
  logic [SlotW-1:0]       rd_addr, wr_addr;
  logic                   wr_ok, res_ok, mark_ok, all_ord, better, use_lasts;
  logic                   is_first, is_last;
  logic [RCW-1:0]         nr;
  logic [RW-1:0]          i_idx;
  logic [4:0]             sat_count;

  assign due_u   = {1'b0, rd_l_q} + {1'b0, rd_d_q};
  assign ext_e   = $signed({{(SlkW-TimeW){1'b0}}, rd_e_q});
  assign ext_due = $signed({{(SlkW-DueW){1'b0}}, due_u});
  assign ext_dur = $signed({{(SlkW-TimeW){1'b0}}, rd_d_q});
  assign hz_s    = $signed({{(SlkW-TimeW){1'b0}}, hz_q});

  assign ct_sel = cnt_q[rsel_q];
  assign ct_cur = cnt_q[cur_q];
  assign i_idx  = i_q[RW-1:0];
  assign nr     = (int'(rc_q) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES) : RCW'(rc_q);
  assign e_m1   = e_q - CW'(1);

  // memory addressing
  always_comb begin
    case (cmd_i)
      CMD_READ_K: rd_idx = k_q;
      CMD_READ_L: rd_idx = l_q;
      default:    rd_idx = j_q;
    endcase
  end
  assign rd_addr = SlotW'(int'(rsel_q) * MAX_TASKS + int'(rd_idx[TW-1:0]));
  assign wr_addr = SlotW'(int'(item_q.resource) * MAX_TASKS + int'(item_q.task_req));
  assign res_ok  = int'(item_q.resource) < MAX_RESOURCES;
  assign wr_ok   = res_ok && (int'(item_q.task_req) < MAX_TASKS);
  assign mark_ok = item_q.has_task && (int'(item_q.task_req) < int'(ct_cur));
  assign sat_count = (int'(item_q.count) > MAX_TASKS) ? 5'(MAX_TASKS) : item_q.count;

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_WR_TASK && wr_ok) begin
      mem_e[wr_addr] <= item_q.earliest;
      mem_l[wr_addr] <= item_q.latest;
      mem_d[wr_addr] <= item_q.duration;
    end
    rd_e_q <= mem_e[rd_addr];
    rd_l_q <= mem_l[rd_addr];
    rd_d_q <= mem_d[rd_addr];
  end

  // every task below the count ordered
  always_comb begin
    all_ord = 1'b1;
    for (int t = 0; t < MAX_TASKS; t++) begin
      if (CW'(t) < ct_cur && !ord_q[cur_q][t]) begin
        all_ord = 1'b0;
      end
    end
  end

  assign better = (cs_q < best_q) || ((cs_q == best_q) && (gs_q < bestg_q));

  // branch pass two classification
  assign up       = (ext_due == max1_q) ? max2_q : max1_q;
  assign down     = (ext_e == min1_q) ? min2_q : min1_q;
  assign is_first = (up - ext_e) >= sum_q;
  assign is_last  = (ext_due - down) >= sum_q;

  // side choice
  always_comb begin
    if (hm_q == CW'(1))                                 use_lasts = 1'b0;
    else if (mode_q == MODE_COUNT && nl_q < nf_q)        use_lasts = 1'b1;
    else if (mode_q == MODE_COUNT && nl_q > nf_q)        use_lasts = 1'b0;
    else if (nf_q == CW'(1))                             use_lasts = 1'b0;
    else if (nl_q == CW'(1))                             use_lasts = 1'b1;
    else if (mode_q == MODE_FIRSTS)                      use_lasts = 1'b0;
    else if (mode_q == MODE_LASTS)                       use_lasts = 1'b1;
    else if (nf_q < CW'(2) || nl_q < CW'(2))             use_lasts = 1'b0;
    else                                                 use_lasts = !(d1_q > d2_q);
  end

  // result selection
  always_comb begin
    out_load          = 1'b1;
    out_d.kind        = kind_q;
    out_d.list_sel    = LIST_NONE;
    out_d.task_id     = '0;
    out_d.resource_id = 3'(cur_q);
    out_d.last        = 1'b1;
    case (cmd_i)
      CMD_EMIT_CAND: begin
        out_d.list_sel = LIST_CAND;
        out_d.task_id  = 4'(e_q[TW-1:0]);
        out_d.last     = 1'b0;
      end
      CMD_EMIT_UO: begin
        out_d.list_sel = LIST_UNORD;
        out_d.task_id  = 4'(e_m1[TW-1:0]);
        out_d.last     = (e_m1[TW-1:0] == lo_q);
      end
      CMD_EMIT_NONE: ;
      CMD_EMIT_FAIL: out_d.kind = KIND_FAILED;
      CMD_EMIT_FIN: begin
        out_d.kind        = KIND_FINISHED;
        out_d.resource_id = '0;
      end
      default: out_load = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q        <= 4'd1;
      mode_q      <= MODE_COUNT;
      hz_q        <= TimeW'(134217726);
      done_q      <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < MAX_RESOURCES; r++) begin
        cnt_q[r] <= '0;
        ord_q[r] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RESOURCE_COUNT: rc_q   <= cfg_wdata_i[3:0];
          REG_CHOICE_MODE:    mode_q <= cfg_wdata_i[1:0];
          REG_HORIZON:        hz_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (cmd_i)
        CMD_WR_COUNT: begin
          if (res_ok) begin
            cnt_q[RW'(item_q.resource)] <= CW'(sat_count);
          end
        end
        CMD_MARK: begin
          if (mark_ok) begin
            ord_q[cur_q][TW'(item_q.task_req)] <= 1'b1;
          end
        end
        CMD_CHECK: begin
          if (all_ord) begin
            done_q[cur_q] <= 1'b1;
            cur_valid_q   <= 1'b0;
          end
        end
        CMD_SEL_SINGLE: begin
          cur_q       <= '0;
          cur_valid_q <= 1'b1;
        end
        CMD_SEL_CMP: begin
          if (better) begin
            cur_q       <= rsel_q;
            cur_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    case (cmd_i)
      CMD_CAPTURE: item_q <= in_item_i;
      CMD_SEL_INIT: begin
        best_q  <= hz_s;
        bestg_q <= hz_s;
        i_q     <= '0;
      end
      CMD_SEL_SKIP: i_q <= i_q + RCW'(1);
      CMD_SCAN_INIT: begin
        rsel_q <= i_idx;
        cs_q   <= hz_s;
        gmin_q <= hz_s;
        gmax_q <= '0;
        gdur_q <= '0;
        j_q    <= '0;
      end
      CMD_J_LOAD: begin
        jm_q   <= ext_e;
        jd_q   <= ext_due;
        gdur_q <= gdur_q + ext_dur;
        if (ext_e < gmin_q) gmin_q <= ext_e;
        if (ext_due > gmax_q) gmax_q <= ext_due;
        k_q    <= '0;
      end
      CMD_J_INC: j_q <= j_q + CW'(1);
      CMD_K_LOAD: begin
        kd_q  <= ext_due;
        dem_q <= '0;
        l_q   <= '0;
      end
      CMD_K_INC: k_q <= k_q + CW'(1);
      CMD_L_ACC: begin
        if (jm_q <= ext_e && ext_due <= kd_q) dem_q <= dem_q + ext_dur;
        l_q <= l_q + CW'(1);
      end
      CMD_VAL_CALC: val_q <= kd_q - jm_q - dem_q;
      CMD_VAL_MIN: begin
        if (val_q < cs_q) cs_q <= val_q;
        k_q <= k_q + CW'(1);
      end
      CMD_GS_CALC: gs_q <= gmax_q - gmin_q - gdur_q;
      CMD_SEL_CMP: begin
        if (better) begin
          best_q  <= cs_q;
          bestg_q <= gs_q;
        end
        i_q <= i_q + RCW'(1);
      end
      CMD_BR_INIT: begin
        rsel_q <= cur_q;
        max1_q <= '1;
        max2_q <= '1;
        min1_q <= hz_s;
        min2_q <= hz_s;
        sum_q  <= '0;
        j_q    <= '0;
      end
      CMD_P1_ACC: begin
        sum_q <= sum_q + ext_dur;
        if (ext_due > max1_q) begin
          max2_q <= max1_q;
          max1_q <= ext_due;
        end else if (ext_due > max2_q) begin
          max2_q <= ext_due;
        end
        if (ext_e < min1_q) begin
          min2_q <= min1_q;
          min1_q <= ext_e;
        end else if (ext_e < min2_q) begin
          min2_q <= ext_e;
        end
        j_q <= j_q + CW'(1);
      end
      CMD_P2_INIT: begin
        nf_q    <= '0;
        nl_q    <= '0;
        hm_q    <= '0;
        fmask_q <= '0;
        lmask_q <= '0;
        uo_q    <= '0;
        a_has_q <= 1'b0;
        b_has_q <= 1'b0;
        c_has_q <= 1'b0;
        e_has_q <= 1'b0;
        j_q     <= '0;
      end
      CMD_P2_ACC: begin
        only_q <= j_q[TW-1:0];
        if (hm_q == '0) lo_q <= j_q[TW-1:0];
        hm_q <= hm_q + CW'(1);
        uo_q[j_q[TW-1:0]] <= 1'b1;
        // two smallest earliest starts among firsts
        if (is_first) begin
          fmask_q[j_q[TW-1:0]] <= 1'b1;
          nf_q <= nf_q + CW'(1);
          if (!a_has_q || ext_e < a_val_q) begin
            b_val_q <= a_val_q;
            b_has_q <= a_has_q;
            a_val_q <= ext_e;
            a_has_q <= 1'b1;
          end else if (!b_has_q || ext_e < b_val_q) begin
            b_val_q <= ext_e;
            b_has_q <= 1'b1;
          end
        end
        // two largest due times among lasts
        if (is_last) begin
          lmask_q[j_q[TW-1:0]] <= 1'b1;
          nl_q <= nl_q + CW'(1);
          if (!c_has_q || ext_due > c_val_q) begin
            e_val_q <= c_val_q;
            e_has_q <= c_has_q;
            c_val_q <= ext_due;
            c_has_q <= 1'b1;
          end else if (!e_has_q || ext_due > e_val_q) begin
            e_val_q <= ext_due;
            e_has_q <= 1'b1;
          end
        end
        j_q <= j_q + CW'(1);
      end
      // the ordering of the pairs keeps both gaps non-negative
      CMD_DIFF: begin
        d1_q <= b_val_q - a_val_q;
        d2_q <= c_val_q - e_val_q;
      end
      CMD_CHOOSE: begin
        kind_q <= use_lasts ? KIND_LASTS : KIND_FIRSTS;
        if (hm_q == CW'(1)) begin
          cand_q <= {{(MAX_TASKS-1){1'b0}}, 1'b1} << only_q;
        end else begin
          cand_q <= use_lasts ? lmask_q : fmask_q;
        end
        e_q <= '0;
      end
      CMD_E_INC, CMD_EMIT_CAND: e_q <= e_q + CW'(1);
      CMD_EM_DOWN_INIT: e_q <= ct_sel;
      CMD_E_DEC, CMD_EMIT_UO: e_q <= e_m1;
      default: ;
    endcase
  end

  // status
  assign st_o.op          = item_q.opcode;
  assign st_o.cur_valid   = cur_valid_q;
  assign st_o.all_ordered = all_ord;
  assign st_o.single      = (nr == RCW'(1)) && !done_q[0];
  assign st_o.i_end       = (i_q == nr);
  assign st_o.i_done      = done_q[i_idx];
  assign st_o.j_end       = (j_q == ct_sel);
  assign st_o.k_end       = (k_q == ct_sel);
  assign st_o.l_end       = (l_q == ct_sel);
  assign st_o.cond_jk     = (jm_q <= ext_e) && (jd_q <= ext_due);
  assign st_o.j_ordered   = ord_q[rsel_q][j_q[TW-1:0]];
  assign st_o.fail        = (hm_q > CW'(1)) && (nf_q == '0 || nl_q == '0);
  assign st_o.e_full      = (e_q == CW'(MAX_TASKS));
  assign st_o.cand_bit    = cand_q[e_q[TW-1:0]];
  assign st_o.e_zero      = (e_q == '0);
  assign st_o.uo_bit      = uo_q[e_m1[TW-1:0]];
  assign st_o.uo_is_lo    = (e_m1[TW-1:0] == lo_q);
  assign st_o.none        = (hm_q == '0);
  assign st_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> rtl/core/resource_firsts_lasts_picker.sv
// Channel   Signals                                 Direction
// input     in_valid_i / in_ready_o / in_item_i     items in (valid/ready)
// output    out_valid_o / out_ready_i / out_item_o  results out (valid/ready)
// config    cfg_we_i / cfg_index_i / cfg_wdata_i    register writes, no wait
//
// Set items are written in S_DECODE. A distribute item marks its task ordered
// on a current resource and branches on it while it has unordered tasks; else
// it scans the slack of every open resource if there are several, branches on
// the winner and emits results. Each table read takes a read state and a use
// state on the single table read port. Reset clears counts, ordered marks and
// the selection; the task tables hold no reset. Results wait in an output
// register; a stalled output holds the sequencer only when a new result is due.
module resource_firsts_lasts_picker import rflp_pkg::*; #(
  parameter int MAX_RESOURCES = MaxResources,
  parameter int MAX_TASKS     = MaxTasks
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rflp_in_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rflp_out_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_wdata_i
);

  dp_cmd_e      cmd;
  rflp_status_t st;

  // sequencer
  rflp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // tables, scan arithmetic and output register
  rflp_dp #(
    .MAX_RESOURCES (MAX_RESOURCES),
    .MAX_TASKS     (MAX_TASKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
